FILE: sv/escape_time_iteration_count_unit_defines.svh
// Assertion macros used by the RTL
`ifndef ESCAPE_TIME_ITERATION_COUNT_UNIT_DEFINES_SVH
`define ESCAPE_TIME_ITERATION_COUNT_UNIT_DEFINES_SVH

// same-cycle implication
`define ETIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("etic: implication check failed");

// next-cycle implication
`define ETIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("etic: next-cycle check failed");

`endif

FILE: sv/etic_pkg.sv
package etic_pkg;

    localparam int COUNT_BITS_DEF     = 16;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int LOG_TABLE_BITS_DEF = 8;

    localparam int ITER_W      = 16;
    localparam int RADIUS_W    = 32;
    localparam int COUNT_W     = 33;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 2;

    localparam int LQ          = 30;
    localparam int WEIGHT_BITS = 16;
    localparam int MULQ_SPLIT  = 16;
    localparam logic [LQ-1:0] LN2_Q30 = 30'd744261118;

    localparam logic [MODE_W-1:0]   COUNT_MODE_RST = 2'd0;
    localparam logic [RADIUS_W-1:0] ESC_RADIUS_RST = 32'd131072;
    localparam logic [RADIUS_W-1:0] ESC_POW_RST    = 32'd262144;
    localparam logic [RADIUS_W-1:0] INV_SPAN_RST   = 32'd32768;
    localparam logic [RADIUS_W-1:0] LOG_ESC_RST    = 32'd45426;
    localparam logic [RADIUS_W-1:0] INV_LOGP_RST   = 32'd94548;

    localparam logic signed [COUNT_W-1:0] OUT_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [COUNT_W-1:0] OUT_MIN = 33'sh1_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COUNT_MODE   = 3'd0,
        REG_ESC_RADIUS   = 3'd1,
        REG_ESC_POW      = 3'd2,
        REG_INV_SPAN     = 3'd3,
        REG_LOG_ESC      = 3'd4,
        REG_INV_LOG_POW  = 3'd5
    } cfg_reg_e;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISCRETE   = 2'd0,
        MODE_CONTINUOUS = 2'd1,
        MODE_SMOOTH     = 2'd2
    } mode_e;

    typedef struct packed {
        logic [ITER_W-1:0]   final_iteration;
        logic [RADIUS_W-1:0] final_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count_value;
        logic                      escaped;
        logic                      saturated;
    } out_item_t;

    // log2 of a Q30 mantissa in [1,2) by repeated squaring
    function automatic logic [63:0] mant_log2(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] y;
        m = m_in;
        y = '0;
        for (int b = LQ - 1; b >= 0; b--) begin
            m = (m * m) >> LQ;
            if (m >= (64'd1 << (LQ + 1))) begin
                m    = m >> 1;
                y[b] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic logic [LQ:0] log_entry(input int i, input int tbits);
        logic [LQ:0]  r;
        logic [63:0]  m;
        if (i >= (1 << tbits)) begin
            r = (LQ + 1)'(1) << LQ;
        end
        else begin
            m = (64'd1 << LQ) + (64'(i) << (LQ - tbits));
            r = (LQ + 1)'(mant_log2(m));
        end
        return r;
    endfunction

endpackage

FILE: sv/escape_time_iteration_count_unit.sv
// Escape-time iteration count, one pixel per transaction.
// Input: drive item (final_iteration, final_radius) and pulse start; busy is
// always low, so a transaction is taken at every clock edge with start high.
// Output: done is high for exactly one cycle with result (count_value,
// escaped, saturated); the receiver cannot hold results off.
// Throughput: one transaction per cycle, set by the eight-stage datapath:
// three table-interpolated log2 units, two ln 2 scaling multipliers, the
// span and 1/ln p multipliers and a final add and clamp stage.
// Configuration: cfg_write, cfg_index and cfg_data write one register per
// edge (0 mode, 1 escape radius, 2 radius power, 3 inverse span,
// 4 ln of escape radius, 5 inverse ln power); write only while idle.
// Reset: rst_n clears the pipeline valid bits and loads the register
// defaults; transactions in flight are dropped.
`include "escape_time_iteration_count_unit_defines.svh"

module escape_time_iteration_count_unit
    import etic_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               item,
    output logic                   done,
    output out_item_t              result
);

    localparam int CW         = (COUNT_BITS < ITER_W) ? COUNT_BITS : ITER_W;
    localparam int PIPE_DEPTH = 8;
    localparam int LATENCY    = PIPE_DEPTH + 1;
    localparam int LA_W       = $clog2(RADIUS_W) + LQ;
    localparam int LR_W       = LA_W + 1;
    localparam int LB_W       = $clog2(RADIUS_W) + LQ;
    localparam int LC_W       = $clog2(LR_W) + LQ;
    localparam int DW         = LC_W + 2;
    localparam int M2_W       = DW;
    localparam int QW         = M2_W - (LQ - FRAC_BITS);
    localparam int SP_W       = QW + RADIUS_W;
    localparam int CP_W       = 2 * RADIUS_W;
    localparam int VW         = CP_W + 2;

    localparam logic signed [VW-1:0] V_MAX = (VW'(1) << (COUNT_W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] V_MIN = -(VW'(1) << (COUNT_W - 1));

    typedef struct packed {
        logic [CW-1:0]   n;
        logic            esc;
        logic            r_gt;
        logic            cont_neg;
        logic [CP_W-1:0] cont_prod;
        logic            lr_zero;
        logic            d_neg;
    } side_t;

    logic [MODE_W-1:0]   mode_reg;
    logic [RADIUS_W-1:0] er_reg, erp_reg, is_reg, ler_reg, ilp_reg;

    logic                valid_reg [PIPE_DEPTH];
    side_t               side_reg  [PIPE_DEPTH];
    side_t               side_next [PIPE_DEPTH];
    logic [RADIUS_W-1:0] r0_reg;
    logic [RADIUS_W-1:0] mag;

    logic [LA_W-1:0]     la;
    logic [LB_W-1:0]     lb;
    logic [LB_W-1:0]     lb3_reg, lb4_reg, lb5_reg;
    logic [LA_W-1:0]     a1;
    logic [LR_W-1:0]     lr;
    logic [LC_W-1:0]     lc;
    logic signed [DW-1:0] d_v;
    logic [DW-2:0]       dm;
    logic [M2_W-1:0]     m2;
    logic [QW-1:0]       q;
    logic [SP_W-1:0]     sprod_next, sprod_reg;

    side_t               s7;
    logic signed [VW-1:0] base_v, base1_v, cterm_v, sterm_v, sum_v;
    logic                sat_v;
    out_item_t           result_next, result_reg;
    logic                done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= COUNT_MODE_RST;
            er_reg   <= ESC_RADIUS_RST;
            erp_reg  <= ESC_POW_RST;
            is_reg   <= INV_SPAN_RST;
            ler_reg  <= LOG_ESC_RST;
            ilp_reg  <= INV_LOGP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COUNT_MODE:  mode_reg <= cfg_data[MODE_W-1:0];
                REG_ESC_RADIUS:  er_reg   <= cfg_data[RADIUS_W-1:0];
                REG_ESC_POW:     erp_reg  <= cfg_data[RADIUS_W-1:0];
                REG_INV_SPAN:    is_reg   <= cfg_data[RADIUS_W-1:0];
                REG_LOG_ESC:     ler_reg  <= cfg_data[RADIUS_W-1:0];
                REG_INV_LOG_POW: ilp_reg  <= cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    etic_log2 #(.IN_W(RADIUS_W), .TAB_BITS(LOG_TABLE_BITS)) u_log_r (
        .clk (clk),
        .x   (r0_reg),
        .y   (la)
    );

    etic_log2 #(.IN_W(RADIUS_W), .TAB_BITS(LOG_TABLE_BITS)) u_log_esc (
        .clk (clk),
        .x   (ler_reg),
        .y   (lb)
    );

    assign a1 = side_reg[2].r_gt ? la - (LA_W'(FRAC_BITS) << LQ) : '0;

    etic_mulq #(.A_W(LA_W)) u_mulq_lr (
        .clk (clk),
        .a   (a1),
        .y   (lr)
    );

    etic_log2 #(.IN_W(LR_W), .TAB_BITS(LOG_TABLE_BITS)) u_log_lr (
        .clk (clk),
        .x   (lr),
        .y   (lc)
    );

    always_comb
    begin
        d_v = $signed(DW'(lb5_reg)) - $signed(DW'(lc))
            + $signed(DW'(LQ - FRAC_BITS) << LQ);
        dm  = (d_v < 0) ? (DW-1)'(-d_v) : (DW-1)'(d_v);
    end

    etic_mulq #(.A_W(DW-1)) u_mulq_d (
        .clk (clk),
        .a   (dm),
        .y   (m2)
    );

    assign q          = QW'(m2 >> (LQ - FRAC_BITS));
    assign sprod_next = SP_W'(q) * SP_W'(ilp_reg);

    always_comb
    begin
        mag = (r0_reg > erp_reg) ? r0_reg - erp_reg : erp_reg - r0_reg;
        side_next[0]   = '0;
        side_next[0].n = item.final_iteration[CW-1:0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[1].esc       = r0_reg >= er_reg;
        side_next[1].r_gt      = r0_reg > (RADIUS_W'(1) << FRAC_BITS);
        side_next[1].cont_neg  = r0_reg > erp_reg;
        side_next[1].cont_prod = CP_W'(mag) * CP_W'(is_reg);
        side_next[4].lr_zero   = (lr == '0);
        side_next[6].d_neg     = (d_v < 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            done_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= item.final_radius;
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            side_reg[k] <= side_next[k];
        end
        lb3_reg    <= lb;
        lb4_reg    <= lb3_reg;
        lb5_reg    <= lb4_reg;
        sprod_reg  <= sprod_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        s7      = side_reg[PIPE_DEPTH-1];
        base_v  = $signed(VW'(s7.n)) <<< FRAC_BITS;
        base1_v = $signed(VW'(s7.n) + VW'(1)) <<< FRAC_BITS;
        cterm_v = $signed(VW'(s7.cont_prod >> FRAC_BITS));
        sterm_v = $signed(VW'(sprod_reg >> FRAC_BITS));
        sat_v   = 1'b0;
        sum_v   = base_v;
        if (!s7.esc)
        begin
            sum_v = -base_v;
        end
        else if (mode_reg == MODE_CONTINUOUS)
        begin
            sum_v = s7.cont_neg ? base_v - cterm_v : base_v + cterm_v;
        end
        else if (mode_reg == MODE_SMOOTH)
        begin
            if (s7.lr_zero)
            begin
                sum_v = V_MAX;
                sat_v = 1'b1;
            end
            else if (ler_reg == '0)
            begin
                sum_v = V_MIN;
                sat_v = 1'b1;
            end
            else
            begin
                sum_v = s7.d_neg ? base1_v - sterm_v : base1_v + sterm_v;
            end
        end
        if (sum_v > V_MAX)
        begin
            sum_v = V_MAX;
            sat_v = 1'b1;
        end
        else if (sum_v < V_MIN)
        begin
            sum_v = V_MIN;
            sat_v = 1'b1;
        end
        result_next.count_value = sum_v[COUNT_W-1:0];
        result_next.escaped     = s7.esc;
        result_next.saturated   = sat_v;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ETIC_ASSERT_NXT(a_latency, clk, rst_n, start && !busy, ##(LATENCY-1) done)
    `ETIC_ASSERT_IMP(a_no_orphan, clk, rst_n, done, $past(start && !busy, LATENCY))
    `ETIC_ASSERT_IMP(a_sat_limit, clk, rst_n, done && result.saturated, result.count_value == OUT_MAX || result.count_value == OUT_MIN)
    `ETIC_ASSERT_IMP(a_not_esc_neg, clk, rst_n, done && !result.escaped, result.count_value <= 0)

endmodule

FILE: sv/etic_log2.sv
module etic_log2
    import etic_pkg::*;
#(
    parameter int IN_W     = 32,
    parameter int TAB_BITS = LOG_TABLE_BITS_DEF,
    localparam int E_W     = $clog2(IN_W),
    localparam int OUT_W   = E_W + LQ
)(
    input  logic             clk,
    input  logic [IN_W-1:0]  x,
    output logic [OUT_W-1:0] y
);

    localparam int XW   = IN_W + TAB_BITS + WEIGHT_BITS;
    localparam int TABN = (1 << TAB_BITS) + 1;

    logic [LQ:0]             tab [TABN];
    logic [E_W-1:0]          e_next, e_reg;
    logic [IN_W-1:0]         norm;
    logic [XW-1:0]           ext;
    logic [TAB_BITS-1:0]     idx_next, idx_reg;
    logic [WEIGHT_BITS-1:0]  w_next, w_reg;
    logic [TAB_BITS:0]       lo_idx, hi_idx;
    logic [LQ:0]             lo, hi, diff;
    logic [LQ+WEIGHT_BITS:0] interp;
    logic [LQ:0]             frac;
    logic [OUT_W-1:0]        y_next, y_reg;

    for (genvar g = 0; g < TABN; g++) begin : g_tab
        localparam logic [LQ:0] ENTRY = log_entry(g, TAB_BITS);
        assign tab[g] = ENTRY;
    end

    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (x[i]) begin
                e_next = E_W'(i);
            end
        end
        norm     = x << (E_W'(IN_W - 1) - e_next);
        ext      = {norm, (TAB_BITS + WEIGHT_BITS)'(0)};
        idx_next = ext[XW-2 -: TAB_BITS];
        w_next   = ext[XW-2-TAB_BITS -: WEIGHT_BITS];
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        idx_reg <= idx_next;
        w_reg   <= w_next;
    end

    always_comb
    begin
        lo_idx = {1'b0, idx_reg};
        hi_idx = lo_idx + (TAB_BITS + 1)'(1);
        lo     = tab[lo_idx];
        hi     = tab[hi_idx];
        diff   = hi - lo;
        interp = (LQ + WEIGHT_BITS + 1)'(diff) * (LQ + WEIGHT_BITS + 1)'(w_reg);
        frac   = lo + (LQ + 1)'(interp >> WEIGHT_BITS);
        y_next = (OUT_W'(e_reg) << LQ) + OUT_W'(frac);
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

FILE: sv/etic_mulq.sv
module etic_mulq
    import etic_pkg::*;
#(
    parameter int A_W   = 36,
    localparam int Y_W  = A_W + 1
)(
    input  logic           clk,
    input  logic [A_W-1:0] a,
    output logic [Y_W-1:0] y
);

    localparam int HI_W = A_W - MULQ_SPLIT + LQ;
    localparam int LO_W = MULQ_SPLIT + LQ;

    logic [HI_W-1:0] hi_prod;
    logic [LO_W-1:0] lo_prod;
    logic [Y_W-1:0]  y_next, y_reg;

    always_comb
    begin
        hi_prod = HI_W'(a[A_W-1:MULQ_SPLIT]) * HI_W'(LN2_Q30);
        lo_prod = LO_W'(a[MULQ_SPLIT-1:0]) * LO_W'(LN2_Q30);
        y_next  = Y_W'(hi_prod >> (LQ - MULQ_SPLIT)) + Y_W'(lo_prod >> LQ);
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule
